@@ src/krkd_pkg.sv @@
// Package for the keyboard report key-difference block.
// Holds slot count, event-entry type and derived widths; no dependencies.
`default_nettype none
package krkd_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int CODE_W    = 8;
  localparam int EV_SLOTS  = 2 * KEY_SLOTS;
  localparam int EV_IDX_W  = $clog2(EV_SLOTS);

  typedef logic [CODE_W-1:0] code_t;

  // presses in slots 0..KEY_SLOTS-1, releases in KEY_SLOTS..EV_SLOTS-1
  typedef struct packed {
    logic [EV_SLOTS-1:0]             mask;
    logic [EV_SLOTS-1:0][CODE_W-1:0] codes;
  } entry_t;

endpackage
`default_nettype wire

@@ src/krkd_front.sv @@
// Front part: keeps the previous report and classifies each new one.
// Uses krkd_pkg; feeds krkd_queue with one event entry per changed report.
`default_nettype none
module krkd_front (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    accept,
  input  wire logic [krkd_pkg::KEY_SLOTS-1:0][krkd_pkg::CODE_W-1:0] fresh,
  output krkd_pkg::entry_t                             entry,
  output logic                                         entry_push
);

  logic [krkd_pkg::KEY_SLOTS-1:0][krkd_pkg::CODE_W-1:0] prev;
  logic [krkd_pkg::KEY_SLOTS-1:0] press;
  logic [krkd_pkg::KEY_SLOTS-1:0] release_mask;

  always_comb begin
    logic hit_old;
    logic hit_new;
    for (int k = 0; k < krkd_pkg::KEY_SLOTS; k++) begin
      hit_old = 1'b0;
      hit_new = 1'b0;
      for (int j = 0; j < krkd_pkg::KEY_SLOTS; j++) begin
        hit_old = hit_old | (prev[j] == fresh[k]);
        hit_new = hit_new | (fresh[j] == prev[k]);
      end
      press[k]        = (fresh[k] != '0) && !hit_old;
      release_mask[k] = (prev[k] != '0) && !hit_new;
    end
  end

  always_comb begin
    entry.mask = {release_mask, press};
    for (int k = 0; k < krkd_pkg::KEY_SLOTS; k++) begin
      entry.codes[k]                      = fresh[k];
      entry.codes[k + krkd_pkg::KEY_SLOTS] = prev[k];
    end
  end

  assign entry_push = accept && (entry.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (accept) begin
      prev <= fresh;
    end
  end

endmodule
`default_nettype wire

@@ src/krkd_queue.sv @@
// Short queue of event entries between front and back parts.
// Uses krkd_pkg; flop storage, one write and one read port.
`default_nettype none
module krkd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  krkd_pkg::entry_t wr_data,
  output logic             full,
  input  wire logic        rd_en,
  output krkd_pkg::entry_t rd_data,
  output logic             rd_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  krkd_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/krkd_back.sv @@
// Back part: walks an entry's event mask into an output register, one event per cycle
// while it is free or popped. Uses krkd_pkg; pulls entries from krkd_queue.
`default_nettype none
module krkd_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  krkd_pkg::entry_t                   q_data,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  output logic                               busy,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [krkd_pkg::CODE_W-1:0]        event_code,
  output logic                               is_press,
  output logic                               last_event
);

  logic [krkd_pkg::EV_SLOTS-1:0]             cur_mask;
  logic [krkd_pkg::EV_SLOTS-1:0][krkd_pkg::CODE_W-1:0] cur_codes;
  logic                                      cur_valid;
  logic                                      out_valid;
  logic [krkd_pkg::EV_IDX_W-1:0]             idx;
  logic [krkd_pkg::EV_SLOTS-1:0]             rest;
  logic                                      out_ready;
  logic                                      fire;
  logic                                      fin;

  always_comb begin
    idx = '0;
    for (int k = krkd_pkg::EV_SLOTS - 1; k >= 0; k--) begin
      if (cur_mask[k]) begin
        idx = krkd_pkg::EV_IDX_W'(k);
      end
    end
  end

  assign rest      = cur_mask & (cur_mask - 1'b1);
  assign fin       = (rest == '0);
  assign out_ready = !out_valid || pop;
  assign fire      = cur_valid && out_ready;
  assign q_pop     = q_valid && (!cur_valid || (fire && fin));
  assign busy      = cur_valid;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_mask  <= q_data.mask;
      cur_codes <= q_data.codes;
    end else if (fire) begin
      cur_mask <= rest;
    end
    if (fire) begin
      event_code <= cur_codes[idx];
      is_press   <= (idx < krkd_pkg::EV_IDX_W'(krkd_pkg::KEY_SLOTS));
      last_event <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (fire && fin) begin
        cur_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/keyboard_report_key_diff.sv @@
// Keyboard report key-difference block, top level.
// Uses krkd_pkg, krkd_front, krkd_queue and krkd_back.
//
// Input channel: one six-slot keyboard report per transfer (push/full).
// Result channel: one key event per transfer (empty/pop): usage code,
// press flag and a mark on the last event a report causes. Presses come
// first in new-slot order, then releases in old-slot order.
// With the back part idle, the first event of a report passes through the
// entry queue, the back part's current-entry register and its output register.
// Throughput: the back part emits one event per cycle while the receiver
// keeps popping; the front part takes a report every cycle while
// the entry queue (QUEUE_DEPTH entries) has room. Reports with no change
// take no queue space.
// Reset clears the stored previous report to all-empty and drops any
// queued or waiting events. When the receiver stalls, the current event
// holds on the result ports, the queue fills and full rises.
`default_nettype none
module keyboard_report_key_diff #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] slot0_code,
  input  wire logic [7:0] slot1_code,
  input  wire logic [7:0] slot2_code,
  input  wire logic [7:0] slot3_code,
  input  wire logic [7:0] slot4_code,
  input  wire logic [7:0] slot5_code,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      event_code,
  output logic            is_press,
  output logic            last_event
);

  logic [krkd_pkg::KEY_SLOTS-1:0][krkd_pkg::CODE_W-1:0] fresh;
  krkd_pkg::entry_t entry;
  krkd_pkg::entry_t q_data;
  logic             entry_push;
  logic             accept;
  logic             q_valid;
  logic             q_pop;
  logic             back_busy;

  assign fresh  = {slot5_code, slot4_code, slot3_code, slot2_code, slot1_code, slot0_code};
  assign accept = push && !full;

  krkd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .fresh      (fresh),
    .entry      (entry),
    .entry_push (entry_push)
  );

  krkd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (entry_push),
    .wr_data  (entry),
    .full     (full),
    .rd_en    (q_pop),
    .rd_data  (q_data),
    .rd_valid (q_valid)
  );

  krkd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (q_data),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .busy       (back_busy),
    .empty      (empty),
    .pop        (pop),
    .event_code (event_code),
    .is_press   (is_press),
    .last_event (last_event)
  );

  a_back_loads: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !back_busy) |=> back_busy)
    else $error("back part idle while an entry waits");

  a_release_follows: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !is_press && !last_event) |=> (empty || !is_press))
    else $error("press after a release within one report");

  a_queue_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("entry taken from an empty queue");

endmodule
`default_nettype wire

@@ test/keyboard_report_key_diff_tb.sv @@
// Testbench for keyboard_report_key_diff: directed and random keyboard reports,
// each event checked against a local key-difference predictor.
// Depends on krkd_pkg and the keyboard_report_key_diff RTL.
`default_nettype none
module keyboard_report_key_diff_tb;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [krkd_pkg::KEY_SLOTS-1:0][krkd_pkg::CODE_W-1:0] report_t;

  typedef struct {
    krkd_pkg::code_t code;
    bit              press;
    bit              is_last;
  } key_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] event_code;
  logic       is_press;
  logic       last_event;
  report_t    report_bus = '0;

  report_t    held_codes = '0;
  key_event_t expected_key_events[$];
  int         error_count = 0;
  int         stall_cycles = 0;
  int         pop_hold = 0;
  bit         idle_on = 1'b1;

  keyboard_report_key_diff dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .slot0_code (report_bus[0]),
    .slot1_code (report_bus[1]),
    .slot2_code (report_bus[2]),
    .slot3_code (report_bus[3]),
    .slot4_code (report_bus[4]),
    .slot5_code (report_bus[5]),
    .empty      (empty),
    .pop        (pop),
    .event_code (event_code),
    .is_press   (is_press),
    .last_event (last_event)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit code_held(input report_t set, input krkd_pkg::code_t c);
    for (int k = 0; k < krkd_pkg::KEY_SLOTS; k++) begin
      if (set[k] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // presses in new-slot order, then releases in old-slot order
  function automatic void predict_key_events(input report_t fresh);
    krkd_pkg::code_t codes [krkd_pkg::EV_SLOTS];
    bit              press [krkd_pkg::EV_SLOTS];
    int              n;
    key_event_t      ev;
    n = 0;
    for (int k = 0; k < krkd_pkg::KEY_SLOTS; k++) begin
      if (fresh[k] != 0 && !code_held(held_codes, fresh[k])) begin
        codes[n] = fresh[k];
        press[n] = 1'b1;
        n++;
      end
    end
    for (int k = 0; k < krkd_pkg::KEY_SLOTS; k++) begin
      if (held_codes[k] != 0 && !code_held(fresh, held_codes[k])) begin
        codes[n] = held_codes[k];
        press[n] = 1'b0;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      ev.code    = codes[i];
      ev.press   = press[i];
      ev.is_last = (i == n - 1);
      expected_key_events.push_back(ev);
    end
    held_codes = fresh;
  endfunction

  function automatic report_t make_report(
      input krkd_pkg::code_t c0, input krkd_pkg::code_t c1, input krkd_pkg::code_t c2,
      input krkd_pkg::code_t c3, input krkd_pkg::code_t c4, input krkd_pkg::code_t c5);
    report_t r;
    r[0] = c0; r[1] = c1; r[2] = c2; r[3] = c3; r[4] = c4; r[5] = c5;
    return r;
  endfunction

  task automatic send_report(input report_t r);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    push       <= 1'b1;
    report_bus <= r;
    do @(posedge clk); while (full !== 1'b0);
    predict_key_events(r);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_key_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly keyboard-like evolution of the held set, some noise
  function automatic report_t random_report();
    report_t r;
    r = held_codes;
    case ($urandom_range(0, 9))
      0, 1: begin
        for (int k = 0; k < krkd_pkg::KEY_SLOTS; k++) r[k] = 8'($urandom_range(0, 255));
      end
      2, 3: begin
        for (int k = 0; k < krkd_pkg::KEY_SLOTS; k++)
          r[k] = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(4, 9));
      end
      4: begin
        if ($urandom_range(0, 1) == 0) r = '0;
      end
      default: begin
        for (int k = 0; k < krkd_pkg::KEY_SLOTS; k++) begin
          case ($urandom_range(0, 6))
            0:       r[k] = 8'h00;
            1:       r[k] = 8'($urandom_range(4, 101));
            2:       r[k] = r[$urandom_range(0, krkd_pkg::KEY_SLOTS - 1)];
            default: r[k] = r[k];
          endcase
        end
      end
    endcase
    return r;
  endfunction

  task automatic test_directed_reports();
    send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(make_report(8'h01, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA));
    send_report(make_report(8'hAA, 8'h55, 8'h7F, 8'h80, 8'hFF, 8'h01));
    send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(make_report(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_report(make_report(8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
    send_report(make_report(8'h0A, 8'h00, 8'h0C, 8'h00, 8'h10, 8'h00));
    send_report(make_report(8'h11, 8'h11, 8'h11, 8'h00, 8'h00, 8'h00));
    send_report(make_report(8'h11, 8'h11, 8'h11, 8'h00, 8'h00, 8'h00));
    send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h11));
    send_report(make_report(8'h12, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(make_report(8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
    send_report(make_report(8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02));
    send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    wait_drained();
  endtask

  task automatic test_random_reports(input int count);
    for (int i = 0; i < count; i++) send_report(random_report());
  endtask

  task automatic test_drain_pause();
    send_report(make_report(8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26));
    wait_drained();
    send_report(make_report(8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36));
    wait_drained();
    send_report(random_report());
    wait_drained();
    send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    test_random_reports(count);
  endtask

  always @(posedge clk) begin
    logic next_pop;
    if (rst) begin
      next_pop = 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold--;
      next_pop = 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      pop_hold = $urandom_range(1, 12) - 1;
      next_pop = 1'b0;
    end else begin
      next_pop = 1'b1;
    end
    pop <= next_pop;
  end

  always @(posedge clk) begin
    key_event_t want;
    if (!rst && pop && !empty) begin
      if (expected_key_events.size() == 0) begin
        $display("%0t: unexpected transfer: code %h press %b last %b",
                 $time, event_code, is_press, last_event);
        error_count++;
      end else begin
        want = expected_key_events.pop_front();
        if (event_code !== want.code) begin
          $display("%0t: event_code expected %h actual %h", $time, want.code, event_code);
          error_count++;
        end
        if (is_press !== want.press) begin
          $display("%0t: is_press expected %b actual %b", $time, want.press, is_press);
          error_count++;
        end
        if (last_event !== want.is_last) begin
          $display("%0t: last_event expected %b actual %b", $time, want.is_last, last_event);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, stall_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_reports();
    test_random_reports(170);
    test_drain_pause();
    test_random_reports(170);
    test_back_to_back(50);
    wait_drained();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
